// ===== src/hed_pkg.sv =====
// ----------------------------------------------------------------------------
// hed_pkg
// Shared types, constants and UTF-8 helpers for the character reference
// decoder.
// ----------------------------------------------------------------------------
package hed_pkg;

    // Code point range limits for UTF-8 length selection
    localparam logic [20:0] CP_MAX_1B  = 21'h00007f;
    localparam logic [20:0] CP_MAX_2B  = 21'h0007ff;
    localparam logic [20:0] CP_MAX_3B  = 21'h00ffff;
    localparam logic [20:0] CP_MAX_ALL = 21'h10ffff;

    // UTF-8 lead and continuation marks
    localparam logic [7:0] LEAD_2B    = 8'hc0;
    localparam logic [7:0] LEAD_3B    = 8'he0;
    localparam logic [7:0] LEAD_4B    = 8'hf0;
    localparam logic [7:0] CONT_MARK  = 8'h80;
    localparam logic [7:0] CONT_MASK  = 8'h3f;
    localparam logic [7:0] CHAR_QMARK = 8'h3f;

    // Word handed from the parser to the emitter
    typedef struct packed {
        logic        is_code;    // numeric reference: expand as UTF-8
        logic [7:0]  data;       // literal byte when not a code
        logic        rep;        // literal byte is a replacement mark
        logic [20:0] code;       // code point when is_code
        logic        ovf;        // code point overflowed
        logic        text_last;  // word closes the text
    } cmd_t;

    // Number of UTF-8 bytes minus one for a valid code point
    function automatic logic [1:0] utf8_len_m1(input logic [20:0] cp);
        logic [1:0] n;
        if (cp <= CP_MAX_1B)
        begin
            n = 2'd0;
        end
        else if (cp <= CP_MAX_2B)
        begin
            n = 2'd1;
        end
        else if (cp <= CP_MAX_3B)
        begin
            n = 2'd2;
        end
        else
        begin
            n = 2'd3;
        end
        return n;
    endfunction

    // One byte of the UTF-8 encoding of cp
    function automatic logic [7:0] utf8_byte(input logic [20:0] cp,
                                             input logic [1:0]  len_m1,
                                             input logic [1:0]  idx);
        logic [7:0] b;
        logic [7:0] c0;
        logic [7:0] c1;
        logic [7:0] c2;
        c0 = CONT_MARK | ({2'b00, cp[5:0]} & CONT_MASK);
        c1 = CONT_MARK | ({2'b00, cp[11:6]} & CONT_MASK);
        c2 = CONT_MARK | ({2'b00, cp[17:12]} & CONT_MASK);
        case (len_m1)
            2'd0:
            begin
                b = cp[7:0];
            end
            2'd1:
            begin
                b = (idx == 2'd0) ? (LEAD_2B | {3'b000, cp[10:6]}) : c0;
            end
            2'd2:
            begin
                case (idx)
                    2'd0:    b = LEAD_3B | {4'b0000, cp[15:12]};
                    2'd1:    b = c1;
                    default: b = c0;
                endcase
            end
            default:
            begin
                case (idx)
                    2'd0:    b = LEAD_4B | {5'b00000, cp[20:18]};
                    2'd1:    b = c2;
                    2'd2:    b = c1;
                    default: b = c0;
                endcase
            end
        endcase
        return b;
    endfunction

endpackage

// ===== src/hed_if.sv =====
// ----------------------------------------------------------------------------
// hed_in_if / hed_out_if
// Valid/ready channels for text bytes in and decoded bytes out.
// ----------------------------------------------------------------------------
interface hed_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       text_end;

    modport source (output valid, output in_byte, output text_end, input ready);
    modport sink   (input valid, input in_byte, input text_end, output ready);
endinterface

interface hed_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;
    logic       text_last;
    logic       replaced;

    modport source (output valid, output out_byte, output run_last,
                    output text_last, output replaced, input ready);
    modport sink   (input valid, input out_byte, input run_last,
                    input text_last, input replaced, output ready);
endinterface

// ===== src/hed_front.sv =====
// ----------------------------------------------------------------------------
// hed_front
// Reference parser: takes one text byte per cycle while the queue is not
// full, tracks reference state and queues at most one emit word per byte.
// ----------------------------------------------------------------------------
module hed_front (
    input  logic          clk,
    input  logic          rst_n,
    hed_in_if.sink        in_ch,
    input  logic          q_full,
    output logic          push,
    output hed_pkg::cmd_t push_data
);

    typedef enum logic [2:0] {
        MODE_PLAIN  = 3'd0,
        MODE_AMP    = 3'd1,
        MODE_HASH   = 3'd2,
        MODE_DIGITS = 3'd3,
        MODE_NAME   = 3'd4
    } mode_t;

    // Name match progress through amp / lt / gt
    localparam logic [3:0] NM_EMPTY = 4'd0;
    localparam logic [3:0] NM_A     = 4'd1;
    localparam logic [3:0] NM_AM    = 4'd2;
    localparam logic [3:0] NM_AMP   = 4'd3;
    localparam logic [3:0] NM_L     = 4'd4;
    localparam logic [3:0] NM_LT    = 4'd5;
    localparam logic [3:0] NM_G     = 4'd6;
    localparam logic [3:0] NM_GT    = 4'd7;
    localparam logic [3:0] NM_FAIL  = 4'd15;

    mode_t       mode_reg, mode_next;
    logic [20:0] value_reg, value_next;
    logic        ovf_reg, ovf_next;
    logic        hex_reg, hex_next;
    logic [3:0]  nm_reg, nm_next;

    logic        accept;
    logic        emit;
    logic        do_digit;
    logic        do_name;
    logic        is_dec;
    logic        is_hex_alpha;
    logic        is_digit;
    logic [3:0]  dig;
    logic [24:0] scaled;
    logic [24:0] acc;
    logic [7:0]  b;

    function automatic logic [3:0] name_step(input logic [3:0] nm, input logic [7:0] c);
        logic [3:0] nx;
        nx = NM_FAIL;
        case (nm)
            NM_EMPTY:
            begin
                if (c == "a")
                begin
                    nx = NM_A;
                end
                else if (c == "l")
                begin
                    nx = NM_L;
                end
                else if (c == "g")
                begin
                    nx = NM_G;
                end
            end
            NM_A:    nx = (c == "m") ? NM_AM : NM_FAIL;
            NM_AM:   nx = (c == "p") ? NM_AMP : NM_FAIL;
            NM_L:    nx = (c == "t") ? NM_LT : NM_FAIL;
            NM_G:    nx = (c == "t") ? NM_GT : NM_FAIL;
            default: nx = NM_FAIL;
        endcase
        return nx;
    endfunction

    assign b           = in_ch.in_byte;
    assign in_ch.ready = !q_full;
    assign accept      = in_ch.valid && !q_full;
    assign push        = accept && emit;

    // Digit classification and accumulation
    assign is_dec       = (b >= "0") && (b <= "9");
    assign is_hex_alpha = hex_reg && (((b >= "a") && (b <= "f")) || ((b >= "A") && (b <= "F")));
    assign is_digit     = is_dec || is_hex_alpha;
    assign dig          = is_dec ? b[3:0] : (b[3:0] + 4'd9);
    assign scaled       = hex_reg ? {value_reg, 4'b0000}
                                  : ({1'b0, value_reg, 3'b000} + {3'b000, value_reg, 1'b0});
    assign acc          = scaled + {21'd0, dig};

    // Next state and emit word
    always_comb
    begin
        mode_next  = mode_reg;
        value_next = value_reg;
        ovf_next   = ovf_reg;
        hex_next   = hex_reg;
        nm_next    = nm_reg;
        emit       = 1'b0;
        do_digit   = 1'b0;
        do_name    = 1'b0;
        push_data  = '0;
        push_data.text_last = in_ch.text_end;

        case (mode_reg)
            MODE_AMP:
            begin
                if (b == "#")
                begin
                    mode_next  = MODE_HASH;
                    value_next = '0;
                    ovf_next   = 1'b0;
                    hex_next   = 1'b0;
                end
                else
                begin
                    mode_next = MODE_NAME;
                    do_name   = 1'b1;
                end
            end
            MODE_HASH:
            begin
                mode_next = MODE_DIGITS;
                if ((b == "x") || (b == "X"))
                begin
                    hex_next = 1'b1;
                end
                else
                begin
                    do_digit = 1'b1;
                end
            end
            MODE_DIGITS:
            begin
                do_digit = 1'b1;
            end
            MODE_NAME:
            begin
                do_name = 1'b1;
            end
            default:
            begin
                if (b == "&")
                begin
                    mode_next  = MODE_AMP;
                    value_next = '0;
                    ovf_next   = 1'b0;
                    hex_next   = 1'b0;
                    nm_next    = NM_EMPTY;
                end
                else
                begin
                    mode_next      = MODE_PLAIN;
                    emit           = 1'b1;
                    push_data.data = b;
                end
            end
        endcase

        // Digit run: accumulate, or close the reference on a non-digit
        if (do_digit)
        begin
            if (!is_digit)
            begin
                emit              = 1'b1;
                push_data.is_code = 1'b1;
                push_data.code    = value_reg;
                push_data.ovf     = ovf_reg;
                mode_next         = MODE_PLAIN;
            end
            else if (!ovf_reg)
            begin
                if (acc > {4'd0, hed_pkg::CP_MAX_ALL})
                begin
                    ovf_next = 1'b1;
                end
                else
                begin
                    value_next = acc[20:0];
                end
            end
        end

        // Name byte: match progress, or resolve on ';'
        if (do_name)
        begin
            if (b == ";")
            begin
                mode_next = MODE_PLAIN;
                emit      = 1'b1;
                case ((mode_reg == MODE_AMP) ? NM_EMPTY : nm_reg)
                    NM_AMP:  push_data.data = "&";
                    NM_LT:   push_data.data = "<";
                    NM_GT:   push_data.data = ">";
                    default:
                    begin
                        push_data.data = hed_pkg::CHAR_QMARK;
                        push_data.rep  = 1'b1;
                    end
                endcase
            end
            else
            begin
                nm_next = name_step((mode_reg == MODE_AMP) ? NM_EMPTY : nm_reg, b);
            end
        end

        // End of text: flush what is pending, then back to reset values
        if (in_ch.text_end)
        begin
            if ((mode_next == MODE_AMP) || (mode_next == MODE_NAME))
            begin
                emit           = 1'b1;
                push_data.data = hed_pkg::CHAR_QMARK;
                push_data.rep  = 1'b1;
            end
            else if ((mode_next == MODE_HASH) || (mode_next == MODE_DIGITS))
            begin
                emit              = 1'b1;
                push_data.is_code = 1'b1;
                push_data.code    = value_next;
                push_data.ovf     = ovf_next;
            end
            mode_next  = MODE_PLAIN;
            value_next = '0;
            ovf_next   = 1'b0;
            hex_next   = 1'b0;
            nm_next    = NM_EMPTY;
        end
    end

    // Parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_PLAIN;
            value_reg <= '0;
            ovf_reg   <= 1'b0;
            hex_reg   <= 1'b0;
            nm_reg    <= NM_EMPTY;
        end
        else if (accept)
        begin
            mode_reg  <= mode_next;
            value_reg <= value_next;
            ovf_reg   <= ovf_next;
            hex_reg   <= hex_next;
            nm_reg    <= nm_next;
        end
    end

    // A closed text leaves the parser idle
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && in_ch.text_end |=> (mode_reg == MODE_PLAIN) && !ovf_reg && !hex_reg)
        else $error("parser state not cleared after end of text");

    // The accumulator never holds a code point beyond the Unicode range
    assert property (@(posedge clk) disable iff (!rst_n)
        value_reg <= hed_pkg::CP_MAX_ALL)
        else $error("accumulated code point out of range");

endmodule

// ===== src/hed_queue.sv =====
// ----------------------------------------------------------------------------
// hed_queue
// Two-entry queue of emit words between the parser and the emitter.
// ----------------------------------------------------------------------------
module hed_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  hed_pkg::cmd_t push_data,
    output logic          full,
    input  logic          pop,
    output logic          head_valid,
    output hed_pkg::cmd_t head_data
);

    hed_pkg::cmd_t slot_reg [2];
    logic          wr_ptr_reg, wr_ptr_next;
    logic          rd_ptr_reg, rd_ptr_next;
    logic [1:0]    count_reg, count_next;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_data  = slot_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
        else $error("push into full queue");

    assert property (@(posedge clk) disable iff (!rst_n) pop |-> head_valid)
        else $error("pop from empty queue");

endmodule

// ===== src/hed_back.sv =====
// ----------------------------------------------------------------------------
// hed_back
// Emitter: expands the head word into one to four output bytes, one per
// cycle while out_ch is not stalled, through a registered output stage.
// ----------------------------------------------------------------------------
module hed_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          head_valid,
    input  hed_pkg::cmd_t head_data,
    output logic          pop,
    hed_out_if.source     out_ch
);

    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic       run_last_reg;
    logic       text_last_reg;
    logic       replaced_reg;
    logic [1:0] idx_reg, idx_next;

    logic       load;
    logic       bad_code;
    logic [1:0] len_m1;
    logic [7:0] cur_byte;
    logic       cur_rep;
    logic       at_end;

    // Byte selection for the head word
    always_comb
    begin
        bad_code = head_data.ovf || (head_data.code > hed_pkg::CP_MAX_ALL);
        len_m1   = 2'd0;
        cur_byte = head_data.data;
        cur_rep  = head_data.rep;
        if (head_data.is_code)
        begin
            if (bad_code)
            begin
                cur_byte = hed_pkg::CHAR_QMARK;
                cur_rep  = 1'b1;
            end
            else
            begin
                len_m1   = hed_pkg::utf8_len_m1(head_data.code);
                cur_byte = hed_pkg::utf8_byte(head_data.code, len_m1, idx_reg);
                cur_rep  = 1'b0;
            end
        end
    end

    assign load     = head_valid && (!out_valid_reg || out_ch.ready);
    assign at_end   = (idx_reg == len_m1);
    assign pop      = load && at_end;
    assign idx_next = pop ? 2'd0 : (idx_reg + 2'd1);

    // Output stage and byte index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
        end
        else
        begin
            if (load)
            begin
                out_valid_reg <= 1'b1;
                idx_reg       <= idx_next;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_byte_reg  <= cur_byte;
            replaced_reg  <= cur_rep;
            run_last_reg  <= at_end;
            text_last_reg <= at_end && head_data.text_last;
        end
    end

    assign out_ch.valid     = out_valid_reg;
    assign out_ch.out_byte  = out_byte_reg;
    assign out_ch.run_last  = run_last_reg;
    assign out_ch.text_last = text_last_reg;
    assign out_ch.replaced  = replaced_reg;

    // Byte index stays inside the current word's encoding
    assert property (@(posedge clk) disable iff (!rst_n)
        head_valid |-> (idx_reg <= len_m1))
        else $error("byte index past end of encoding");

endmodule

// ===== src/html_entity_decoder_utf8.sv =====
// ----------------------------------------------------------------------------
// html_entity_decoder_utf8
// Streaming HTML character reference decoder with UTF-8 output.
// ----------------------------------------------------------------------------
// The decoder takes one text byte per cycle while its queue has room and
// returns one output byte per cycle while out_ch is ready. Plain text and
// named references pass at one byte per cycle in each direction; a numeric
// reference closes with one to four UTF-8 bytes, which leave the output
// stage one per cycle, so a long run of multi-byte references is bounded
// by the output port. A two-word queue between the parser and the emitter
// lets input continue while the emitter expands a code point, and the output
// register lets the next input be taken while a byte waits on out_ch.
// ----------------------------------------------------------------------------
module html_entity_decoder_utf8 (
    input  logic      clk,
    input  logic      rst_n,
    hed_in_if.sink    in_ch,
    hed_out_if.source out_ch
);

    logic          push;
    hed_pkg::cmd_t push_data;
    logic          q_full;
    logic          pop;
    logic          head_valid;
    hed_pkg::cmd_t head_data;

    hed_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .q_full    (q_full),
        .push      (push),
        .push_data (push_data)
    );

    hed_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_data  (head_data)
    );

    hed_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_data  (head_data),
        .pop        (pop),
        .out_ch     (out_ch)
    );

endmodule
